### hw/rtl/fbpa_pkg.sv
// Shared constants for the fixed block pool allocator.
package fbpa_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int BYTES_W    = 17;
  localparam int ADDR_W     = 32;
  localparam int PROD_W     = IDX_W + BYTES_W;

  localparam logic [CNT_W-1:0] COUNT_CAP   = CNT_W'(MAX_BLOCKS < 1024 ? MAX_BLOCKS : 1024);
  localparam logic [CNT_W-1:0] COUNT_RESET = COUNT_CAP;

  localparam logic [1:0] CFG_BLOCK_COUNT  = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BYTES  = 2'd1;
  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

endpackage

### hw/rtl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: request handling, pool state and result register.
//
// Requests arrive on the s_ side, one word each: s_tuser is the request kind
// (allocate or free) and s_tdata carries the index of a block being returned.
// Every request yields exactly one result word on the m_ side: status in
// m_tuser, block index, block address and free count in m_tdata.
// In the accept cycle of a request the lazy link write and the head-link
// read go to the link RAM; in the next cycle the registered read data arrives.
// Once the output register is free, the head, free count and touched count are
// updated and the result is loaded; s_tready rises again the cycle after that.
// No new request is taken while one is in flight: s_tready stays low until it ends.
// A finished result waits in the output register while the next request is
// taken; if the receiver still stalls when that request completes, the block
// holds it and keeps s_tready low until the output register frees.
// Reset clears the handshake state and restarts the pool with 1024 blocks of
// eight bytes at address zero. The link RAM is not cleared: links are built
// lazily, one per allocate. Writing block_count restarts the pool the same way.
// Configuration writes take effect at once; the user must make them only while idle (unchecked).
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] free_index
  input  logic [0:0]  s_tuser,   // [0] req_type
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [9:0] block_index, [41:10] block_address, [52:42] free_blocks
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic               state;
  logic [CNT_W-1:0]   block_count;
  logic [BYTES_W-1:0] block_bytes;
  logic [ADDR_W-1:0]  base_address;
  logic [CNT_W-1:0]   head_index;
  logic [CNT_W-1:0]   free_total;
  logic [CNT_W-1:0]   touched_count;

  logic               req_r;
  logic [IDX_W-1:0]   fidx_r;

  logic [CNT_W-1:0]   link_rdata;

  logic [1:0]         out_status;
  logic [IDX_W-1:0]   out_index;
  logic [ADDR_W-1:0]  out_address;
  logic [CNT_W-1:0]   out_free;

  logic               s_accept;
  logic               finish;
  logic               in_req;
  logic [IDX_W-1:0]   in_idx;
  logic               lazy_en;
  logic               free_ok_in;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [CNT_W-1:0]   ram_wdata;
  logic [CNT_W-1:0]   count_lim;

  logic               alloc_ok;
  logic               free_ok;
  logic               fwd;
  logic [CNT_W-1:0]   next_head;
  logic [PROD_W-1:0]  prod;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_index;
  logic [ADDR_W-1:0]  res_address;
  logic [CNT_W-1:0]   free_total_next;
  logic [CNT_W-1:0]   head_index_next;
  logic [CNT_W-1:0]   touched_count_next;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign finish   = (state == S_BUSY) && (!m_tvalid || m_tready);
  assign in_req   = s_tuser[0];
  assign in_idx   = s_tdata[IDX_W-1:0];

  assign lazy_en    = touched_count < block_count;
  assign free_ok_in = ({1'b0, in_idx} < block_count) && (free_total < block_count);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = touched_count[IDX_W-1:0];
    ram_wdata = touched_count + CNT_W'(1);
    if (s_accept) begin
      if (in_req == REQ_ALLOC) begin
        ram_we = lazy_en;
      end else begin
        ram_we    = free_ok_in;
        ram_waddr = in_idx;
        ram_wdata = head_index;
      end
    end
  end

  fbpa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s_accept),
    .raddr (head_index[IDX_W-1:0]),
    .rdata (link_rdata)
  );

  // the lazy write of this request may hit the head entry itself
  assign fwd       = lazy_en && (touched_count == head_index);
  assign next_head = fwd ? (touched_count + CNT_W'(1)) : link_rdata;
  assign prod      = PROD_W'(head_index[IDX_W-1:0]) * PROD_W'(block_bytes);

  assign alloc_ok = (free_total != '0) && (head_index < block_count);
  assign free_ok  = ({1'b0, fidx_r} < block_count) && (free_total < block_count);

  always_comb begin
    res_status         = ST_DONE;
    res_index          = '0;
    res_address        = '0;
    free_total_next    = free_total;
    head_index_next    = head_index;
    touched_count_next = touched_count;
    if (req_r == REQ_ALLOC) begin
      if (lazy_en) begin
        touched_count_next = touched_count + CNT_W'(1);
      end
      if (alloc_ok) begin
        res_index       = head_index[IDX_W-1:0];
        res_address     = base_address + ADDR_W'(prod);
        free_total_next = free_total - CNT_W'(1);
        if (free_total_next != '0) begin
          head_index_next = next_head;
        end
      end else begin
        res_status = ST_EMPTY;
      end
    end else begin
      if (free_ok) begin
        head_index_next = {1'b0, fidx_r};
        free_total_next = free_total + CNT_W'(1);
      end else begin
        res_status = ST_BAD_FREE;
      end
    end
  end

  always_comb begin
    if (cfg_data[CNT_W-1:0] == '0) begin
      count_lim = CNT_W'(1);
    end else if (cfg_data[CNT_W-1:0] > COUNT_CAP) begin
      count_lim = COUNT_CAP;
    end else begin
      count_lim = cfg_data[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      block_count   <= COUNT_RESET;
      block_bytes   <= BYTES_W'(8);
      base_address  <= '0;
      head_index    <= '0;
      free_total    <= COUNT_RESET;
      touched_count <= '0;
    end else begin
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            state <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (finish) begin
            state         <= S_IDLE;
            head_index    <= head_index_next;
            free_total    <= free_total_next;
            touched_count <= touched_count_next;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_COUNT: begin
            block_count   <= count_lim;
            head_index    <= '0;
            free_total    <= count_lim;
            touched_count <= '0;
          end
          CFG_BLOCK_BYTES:  block_bytes  <= cfg_data[BYTES_W-1:0];
          CFG_BASE_ADDRESS: base_address <= cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      req_r  <= in_req;
      fidx_r <= in_idx;
    end
    if (finish) begin
      out_status  <= res_status;
      out_index   <= res_index;
      out_address <= res_address;
      out_free    <= free_total_next;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_free, out_address, out_index};

  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    free_total <= block_count)
    else $error("free count above block count");

  a_touched_bounded: assert property (@(posedge clk) disable iff (rst)
    touched_count <= block_count)
    else $error("touched count above block count");

  a_alloc_decrements: assert property (@(posedge clk) disable iff (rst)
    (finish && req_r == REQ_ALLOC && alloc_ok && !cfg_we) |=>
      (free_total == $past(free_total) - CNT_W'(1)))
    else $error("done allocate did not take a block");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    finish |=> m_tvalid && state == S_IDLE)
    else $error("finished request did not present a result");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fixed block pool allocator: directed and random requests.

import fbpa_pkg::*;

typedef struct packed {
  logic [1:0]        status;
  logic [IDX_W-1:0]  index;
  logic [ADDR_W-1:0] address;
  logic [CNT_W-1:0]  free_cnt;
} pool_result_t;

class pool_scoreboard;
  logic [CNT_W-1:0]   link_mem [MAX_BLOCKS];
  logic [CNT_W-1:0]   head, free_total, touched, count;
  logic [BYTES_W-1:0] bytes;
  logic [ADDR_W-1:0]  base;
  pool_result_t       owed_results[$];
  int errors, checked, empties, bad_frees;

  function new();
    count = COUNT_RESET;
    bytes = BYTES_W'(8);
    base = '0;
    errors = 0;
    checked = 0;
    empties = 0;
    bad_frees = 0;
    restart();
  endfunction

  function void restart();
    head = '0;
    free_total = count;
    touched = '0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] value);
    logic [CNT_W-1:0] v;
    v = value[CNT_W-1:0];
    case (idx)
      CFG_BLOCK_COUNT: begin
        if (v == '0) count = CNT_W'(1);
        else if (v > COUNT_CAP) count = COUNT_CAP;
        else count = v;
        restart();
      end
      CFG_BLOCK_BYTES: bytes = value[BYTES_W-1:0];
      CFG_BASE_ADDRESS: base = value;
      default: ;
    endcase
  endfunction

  // Accepted request: advance the pool and queue the word it owes.
  function pool_result_t take_request(logic req, logic [IDX_W-1:0] fidx);
    pool_result_t r;
    r = '0;
    if (req == REQ_ALLOC) begin
      // lazy link of the next untouched block
      if (touched < count) begin
        link_mem[touched[IDX_W-1:0]] = touched + 1'b1;
        touched = touched + 1'b1;
      end
      if (free_total == 0 || head >= count) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_DONE;
        r.index = head[IDX_W-1:0];
        r.address = base + 32'(r.index) * 32'(bytes);
        free_total = free_total - 1'b1;
        if (free_total != 0) head = link_mem[r.index];
      end
    end else if (fidx >= count || free_total >= count) begin
      r.status = ST_BAD_FREE;
    end else begin
      r.status = ST_DONE;
      link_mem[fidx] = head;
      head = {1'b0, fidx};
      free_total = free_total + 1'b1;
    end
    r.free_cnt = free_total;
    if (r.status == ST_EMPTY) empties++;
    if (r.status == ST_BAD_FREE) bad_frees++;
    owed_results.push_back(r);
    return r;
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task match_result(pool_result_t got);
    pool_result_t want;
    checked++;
    if (owed_results.size() == 0) begin
      report($sformatf("word %0d arrived with nothing owed", checked));
      return;
    end
    want = owed_results.pop_front();
    if (got.status != want.status)
      report($sformatf("word %0d status %0d, want %0d", checked, got.status, want.status));
    if (got.index != want.index)
      report($sformatf("word %0d index %0d, want %0d", checked, got.index, want.index));
    if (got.address != want.address)
      report($sformatf("word %0d address %h, want %h", checked, got.address, want.address));
    if (got.free_cnt != want.free_cnt)
      report($sformatf("word %0d free %0d, want %0d", checked, got.free_cnt, want.free_cnt));
  endtask
endclass

module tb;
  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;

  pool_scoreboard sb = new();
  int held_blocks[$];
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int gap_free = 0;
  int items_sent = 0;
  int allocs_sent = 0;
  int settings_used = 1;

  always #10 clk = ~clk;

  fixed_block_pool_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.match_result({m_tuser, m_tdata[9:0], m_tdata[41:10], m_tdata[52:42]});
  end

  initial begin : receiver
    int hold;
    hold = 0;
    m_tready <= 1'b0;
    forever @(posedge clk) begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 60;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(0, 11);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d words still owed", sb.owed_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic issue(input logic req, input logic [IDX_W-1:0] fidx);
    pool_result_t r;
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= 16'(fidx);
    do @(posedge clk); while (!s_tready);
    r = sb.take_request(req, fidx);
    items_sent++;
    if (req == REQ_ALLOC) allocs_sent++;
    if (req == REQ_ALLOC && r.status == ST_DONE) held_blocks.push_back(int'(r.index));
    if (gap_free > 0) begin
      gap_free--;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pool(input logic [31:0] cnt, input logic [31:0] bytes_v,
                          input logic [31:0] base_v);
    logic [1:0]  regs [3];
    logic [31:0] vals [3];
    regs = '{CFG_BLOCK_COUNT, CFG_BLOCK_BYTES, CFG_BASE_ADDRESS};
    vals = '{cnt, bytes_v, base_v};
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    held_blocks.delete();
    settings_used++;
  endtask

  // Mostly allocate/free of held blocks; early half fills, late half drains.
  task automatic run_phase(input int n, input bit hold_mid, input bit drain_mid);
    int r;
    int k;
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 3) begin
        long_hold_req = 1'b1;
        gap_free = 12;
      end
      if (drain_mid && i == n / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        idx = IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
        issue(REQ_FREE, idx);
      end else if (held_blocks.size() > 0 && r < (i < n / 2 ? 38 : 70)) begin
        k = $urandom_range(0, held_blocks.size() - 1);
        idx = IDX_W'(held_blocks[k]);
        held_blocks.delete(k);
        issue(REQ_FREE, idx);
      end else begin
        issue(REQ_ALLOC, '0);
      end
    end
  endtask

  initial begin
    int counts [8];
    logic [31:0] cnt, bytes_v, base_v;
    counts = '{1024, 1, 2047, 5, 0, 0, 2, 16};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BLOCK_COUNT;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= REQ_ALLOC;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pool: free while all free, allocs from the lazy list, reuse, stray free
    issue(REQ_FREE, 10'd5);
    repeat (3) issue(REQ_ALLOC, '0);
    issue(REQ_FREE, 10'd1);
    issue(REQ_ALLOC, '0);
    issue(REQ_FREE, 10'd1023);

    // two large blocks at the top of memory: address wrap, empty, bad frees
    set_pool(2, 65536, 32'hFFFF_FFF8);
    repeat (3) issue(REQ_ALLOC, '0);
    issue(REQ_FREE, 10'd2);
    issue(REQ_FREE, 10'd0);
    issue(REQ_FREE, 10'd1);
    issue(REQ_FREE, 10'd0);
    issue(REQ_ALLOC, '0);

    // zero count is taken as one block
    set_pool(0, 8, 0);
    repeat (2) issue(REQ_ALLOC, '0);
    issue(REQ_FREE, 10'd1);
    issue(REQ_FREE, 10'd0);
    issue(REQ_FREE, 10'd0);

    // free of a never-allocated block drives the head past the pool
    set_pool(3, 8, 0);
    repeat (2) issue(REQ_ALLOC, '0);
    issue(REQ_FREE, 10'd2);
    repeat (2) issue(REQ_ALLOC, '0);
    issue(REQ_FREE, 10'd0);
    issue(REQ_ALLOC, '0);

    for (int ph = 0; ph < 8; ph++) begin
      cnt = (ph == 5) ? $urandom_range(3, 1023) : counts[ph];
      bytes_v = (ph == 0) ? 8 : (ph == 2) ? 65536 : $urandom_range(1, 8192) * 8;
      base_v = (ph == 1) ? 0 : (ph == 3) ? 32'hFFFF_FFF8 : ($urandom & 32'hFFFF_FFF8);
      set_pool(cnt, bytes_v, base_v);
      quiet = (ph == 7);
      run_phase(66, ph == 3, ph == 5);
    end

    s_tvalid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests (%0d allocate, %0d free) over %0d pool settings",
             items_sent, allocs_sent, items_sent - allocs_sent, settings_used);
    $display("%0d result words compared: %0d empty answers, %0d rejected frees, %0d mismatches",
             sb.checked, sb.empties, sb.bad_frees, sb.errors);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
